/* hdl/nts_pkg.sv */
package nts_pkg;

    // symbol codes
    typedef logic [4:0] t_sym;

    localparam t_sym C_SYM_REP_A = 5'd16;
    localparam t_sym C_SYM_REP_B = 5'd17;
    localparam t_sym C_SYM_MARK  = 5'd18;
    localparam t_sym C_SYM_END   = 5'd19;
    localparam t_sym C_NO_NIBBLE = 5'd20;

    // crc setup
    localparam logic [15:0] C_CRC_INIT = 16'h0101;
    localparam logic [15:0] C_CRC_POLY = 16'hA001;

    // payload length limit
    localparam logic [10:0] C_MAX_PAYLOAD = 11'd1024;

    // configuration register indexes
    localparam logic C_REG_PAYLOAD_LEN = 1'b0;
    localparam logic C_REG_SEP_OFFSET  = 1'b1;

    // result of sending one nibble through the repeat coder
    typedef struct packed {
        t_sym sym;
        logic phase;
    } t_nib_res;

    // reflected crc-16 over one byte
    function automatic logic [15:0] nts_crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ C_CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    // a nibble equal to the previous one becomes an alternating repeat symbol
    function automatic t_nib_res nts_nib_step(input logic [3:0] nib, input t_sym prev,
                                              input logic phase);
        t_nib_res res;
        if ({1'b0, nib} != prev) begin
            res.sym   = {1'b0, nib};
            res.phase = 1'b0;
        end else if (!phase) begin
            res.sym   = C_SYM_REP_A;
            res.phase = 1'b1;
        end else begin
            res.sym   = C_SYM_REP_B;
            res.phase = 1'b0;
        end
        return res;
    endfunction

endpackage

/* hdl/nts_byte_if.sv */
interface nts_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

/* hdl/nts_sym_if.sv */
interface nts_sym_if;
    logic       valid;
    logic       ready;
    logic [4:0] symbol;
    logic       last;

    modport source (output valid, output symbol, output last, input ready);
    modport sink (input valid, input symbol, input last, output ready);
endinterface

/* hdl/nibble_tone_symbol_framer_unit.sv */
// order: an accepted item waits in the input register and is coded into the result
//   buffer once the buffer is empty or its last symbol is taken; symbols leave from there
// throughput: one symbol per cycle while o_out.ready is high; an item holds the buffer
//   until its last symbol is taken (2 for a plain mid-frame byte, up to 13 at frame ends)
// reset: synchronous active low; clears frame state, empties the buffers, payload_len 1,
//   sep_offset 0
module nibble_tone_symbol_framer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    nts_byte_if.sink    i_in,
    nts_sym_if.source   o_out,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [10:0] i_cfg_data
);
    import nts_pkg::*;

    localparam int NSLOT = 15;
    localparam int NNIB  = 10;
    // buffer positions of the ten nibble symbols
    localparam int NIB_SLOT [NNIB] = '{1, 2, 3, 4, 6, 7, 9, 10, 12, 13};

    // configuration
    logic [10:0] r_payload_len;
    logic [10:0] r_sep_offset;

    // frame state
    logic [10:0] r_byte_idx, n_byte_idx;
    logic [15:0] r_crc, n_crc;
    t_sym        r_prev, n_prev;
    logic        r_phase, n_phase;

    // input register
    logic        r_in_valid;
    logic [7:0]  r_in_byte;

    // result buffer
    t_sym              r_sym [NSLOT];
    logic [NSLOT-1:0]  r_mask;
    t_sym              n_sym [NSLOT];
    logic [NSLOT-1:0]  n_mask;

    logic [10:0] w_len;
    logic [15:0] w_total;
    logic [15:0] w_crc_hdr;
    logic [15:0] w_crc_new;
    logic        w_first;
    logic        w_is_last;
    logic [3:0]  w_nib [NNIB];
    logic [NNIB-1:0] w_nib_en;
    t_sym        w_prev;
    logic        w_phase;
    t_nib_res    w_res;

    logic [NSLOT-1:0] w_pick;
    t_sym        w_out_sym;
    logic        w_out_last;
    logic        w_take;
    logic        w_load;
    logic        w_in_ready;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_payload_len <= 11'd1;
            r_sep_offset  <= 11'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                C_REG_PAYLOAD_LEN: r_payload_len <= i_cfg_data;
                C_REG_SEP_OFFSET:  r_sep_offset  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // effective length, header crc and crc updated with the current byte
    always_comb begin
        if (r_payload_len == 11'd0) begin
            w_len = 11'd1;
        end else if (r_payload_len > C_MAX_PAYLOAD) begin
            w_len = C_MAX_PAYLOAD;
        end else begin
            w_len = r_payload_len;
        end
        w_total   = {5'd0, w_len} + 16'd4;
        w_first   = (r_byte_idx == 11'd0);
        w_is_last = ({1'b0, r_byte_idx} + 12'd1) >= {1'b0, w_len};
        w_crc_hdr = nts_crc_byte(nts_crc_byte(C_CRC_INIT, w_total[7:0]), w_total[15:8]);
        w_crc_new = nts_crc_byte(w_first ? w_crc_hdr : r_crc, r_in_byte);
    end

    // nibble list in frame order
    always_comb begin
        w_nib[0] = w_total[7:4];
        w_nib[1] = w_total[3:0];
        w_nib[2] = w_total[15:12];
        w_nib[3] = w_total[11:8];
        w_nib[4] = r_in_byte[7:4];
        w_nib[5] = r_in_byte[3:0];
        w_nib[6] = w_crc_new[7:4];
        w_nib[7] = w_crc_new[3:0];
        w_nib[8] = w_crc_new[15:12];
        w_nib[9] = w_crc_new[11:8];
        w_nib_en = {{4{w_is_last}}, 2'b11, {4{w_first}}};
    end

    // symbol slots and next frame state
    always_comb begin
        for (int s = 0; s < NSLOT; s++) begin
            n_sym[s] = C_SYM_MARK;
        end
        n_mask    = '0;
        n_mask[0] = w_first;
        n_mask[5] = (r_byte_idx == r_sep_offset);
        n_mask[8] = w_is_last && (w_len == r_sep_offset);
        n_mask[11] = w_is_last && (({1'b0, w_len} + 12'd1) == {1'b0, r_sep_offset});
        n_mask[14] = w_is_last;
        n_sym[14] = C_SYM_END;

        // repeat coder chain
        w_prev  = r_prev;
        w_phase = r_phase;
        w_res   = '0;
        for (int k = 0; k < NNIB; k++) begin
            if (w_nib_en[k]) begin
                w_res               = nts_nib_step(w_nib[k], w_prev, w_phase);
                n_sym[NIB_SLOT[k]]  = w_res.sym;
                n_mask[NIB_SLOT[k]] = 1'b1;
                w_phase             = w_res.phase;
                w_prev              = {1'b0, w_nib[k]};
            end
        end

        if (w_is_last) begin
            n_byte_idx = 11'd0;
            n_crc      = C_CRC_INIT;
            n_prev     = C_NO_NIBBLE;
            n_phase    = 1'b0;
        end else begin
            n_byte_idx = r_byte_idx + 11'd1;
            n_crc      = w_crc_new;
            n_prev     = w_prev;
            n_phase    = w_phase;
        end
    end

    // output selection: lowest pending slot
    always_comb begin
        w_pick    = r_mask & (~r_mask + 1'b1);
        w_out_sym = '0;
        for (int s = 0; s < NSLOT; s++) begin
            if (w_pick[s]) begin
                w_out_sym = r_sym[s];
            end
        end
        w_out_last = ((r_mask & ~w_pick) == '0);
    end

    assign w_take     = (r_mask != '0) && o_out.ready;
    assign w_load     = r_in_valid && ((r_mask == '0) || (w_take && w_out_last));
    assign w_in_ready = !r_in_valid || w_load;

    assign i_in.ready   = w_in_ready;
    assign o_out.valid  = (r_mask != '0);
    assign o_out.symbol = w_out_sym;
    assign o_out.last   = w_out_last;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_ready && i_in.valid) begin
            r_in_byte <= i_in.data_byte;
        end
    end

    // frame state and result buffer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_idx <= 11'd0;
            r_crc      <= C_CRC_INIT;
            r_prev     <= C_NO_NIBBLE;
            r_phase    <= 1'b0;
            r_mask     <= '0;
        end else if (w_load) begin
            r_byte_idx <= n_byte_idx;
            r_crc      <= n_crc;
            r_prev     <= n_prev;
            r_phase    <= n_phase;
            r_mask     <= n_mask;
        end else if (w_take) begin
            r_mask <= r_mask & ~w_pick;
        end
    end

    // result buffer payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            for (int s = 0; s < NSLOT; s++) begin
                r_sym[s] <= n_sym[s];
            end
        end
    end

endmodule

/* hdl/nts_checker.sv */
module nts_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [4:0] i_out_symbol,
    input logic       i_out_last
);
    import nts_pkg::*;

    logic w_in_take;
    logic w_out_take;
    logic r_after_end, n_after_end;

    assign w_in_take  = i_in_valid && i_in_ready;
    assign w_out_take = i_out_valid && i_out_ready;

    // remembers that the last symbol taken closed a frame
    always_comb begin
        n_after_end = r_after_end;
        if (w_out_take) begin
            n_after_end = (i_out_symbol == C_SYM_END);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_after_end <= 1'b0;
        end else begin
            r_after_end <= n_after_end;
        end
    end

    // no tone index beyond the end symbol
    a_symbol_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_symbol <= C_SYM_END))
        else $error("symbol out of range");

    // a stalled symbol holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_symbol) && $stable(i_out_last)))
        else $error("stalled output changed");

    // the end symbol closes the item
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_take && (i_out_symbol == C_SYM_END)) |-> i_out_last)
        else $error("end symbol without last");

    // a new frame opens with the start symbol
    a_start_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_take && r_after_end) |-> (i_out_symbol == C_SYM_MARK))
        else $error("frame did not open with start symbol");

    // an item ready to enter is never refused while nothing is pending on the output
    a_in_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_out_valid && !$past(w_in_take) && !$past(i_out_valid) && $past(i_rst_n))
            |-> i_in_ready)
        else $error("input refused while idle");

endmodule

bind nibble_tone_symbol_framer_unit nts_checker u_nts_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_symbol (o_out.symbol),
    .i_out_last   (o_out.last)
);

/* verif/tb_nibble_tone_symbol_framer_unit.sv */
module tb_nibble_tone_symbol_framer_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import nts_pkg::*;

    typedef struct packed {
        t_sym sym;
        logic last;
    } t_sym_exp;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [10:0] i_cfg_data;

    nts_byte_if in_if ();
    nts_sym_if  out_if ();

    nibble_tone_symbol_framer_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // framer state as the block should hold it
    logic [10:0] cfg_len;
    logic [10:0] cfg_sep;
    int unsigned frm_idx;
    logic [15:0] frm_crc;
    t_sym        prev_nib;
    logic        rep_phase;

    t_sym        step_syms[$];
    t_sym_exp    expected_syms[$];

    bit          stall_on;
    logic [7:0]  prev_byte;
    int unsigned fail_cnt;
    int unsigned items_sent;
    int unsigned syms_checked;
    int unsigned frames_done;
    int unsigned cfg_writes;

    // clock
    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // run limit
    initial begin
        #2_000_000;
        $display("[nibble_tone_symbol_framer_unit] ERROR");
        $finish;
    end

    // symbol sink with random back-pressure
    initial begin : ready_drive
        int unsigned hold;
        hold = 0;
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                out_if.ready <= 1'b0;
                hold--;
            end else if (stall_on && $urandom_range(0, 4) == 0) begin
                out_if.ready <= 1'b0;
                hold = $urandom_range(0, 2);
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    // compare each accepted symbol with the oldest expectation
    always @(posedge i_clk) begin
        t_sym_exp e;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (expected_syms.size() == 0) begin
                $error("unexpected symbol %0d last %0d", out_if.symbol, out_if.last);
                fail_cnt++;
            end else begin
                e = expected_syms.pop_front();
                syms_checked++;
                if (out_if.symbol !== e.sym) begin
                    $error("symbol: expected %0d actual %0d", e.sym, out_if.symbol);
                    fail_cnt++;
                end
                if (out_if.last !== e.last) begin
                    $error("last: expected %0d actual %0d", e.last, out_if.last);
                    fail_cnt++;
                end
            end
        end
    end

    function automatic int unsigned eff_length();
        if (cfg_len == 11'd0) begin
            return 1;
        end else if (cfg_len > C_MAX_PAYLOAD) begin
            return int'(C_MAX_PAYLOAD);
        end
        return int'(cfg_len);
    endfunction

    function automatic void frame_restart();
        frm_idx   = 0;
        frm_crc   = C_CRC_INIT;
        prev_nib  = C_NO_NIBBLE;
        rep_phase = 1'b0;
    endfunction

    function automatic void push_sym(t_sym s);
        if (step_syms.size() < 16) begin
            step_syms.push_back(s);
        end
    endfunction

    // repeat coder: a nibble equal to the previous one alternates 16 / 17
    function automatic void code_nibble(logic [3:0] nib);
        if ({1'b0, nib} != prev_nib) begin
            push_sym({1'b0, nib});
            rep_phase = 1'b0;
        end else if (!rep_phase) begin
            push_sym(C_SYM_REP_A);
            rep_phase = 1'b1;
        end else begin
            push_sym(C_SYM_REP_B);
            rep_phase = 1'b0;
        end
        prev_nib = {1'b0, nib};
    endfunction

    // one frame byte, with the separator in front at its slot
    function automatic void code_frame_byte(logic [7:0] b, int unsigned pos);
        if (pos == int'(cfg_sep) + 2) begin
            push_sym(C_SYM_MARK);
        end
        code_nibble(b[7:4]);
        code_nibble(b[3:0]);
    endfunction

    function automatic void crc_update(logic [7:0] b);
        logic [15:0] c;
        logic        lsb;
        c = frm_crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            lsb = c[0];
            c   = c >> 1;
            if (lsb) begin
                c = c ^ C_CRC_POLY;
            end
        end
        frm_crc = c;
    endfunction

    // symbols that one payload byte causes
    function automatic void predict_symbols(logic [7:0] b);
        int unsigned len;
        logic [15:0] total;
        logic [15:0] crc;
        t_sym_exp    e;
        len = eff_length();
        step_syms.delete();
        if (frm_idx == 0) begin
            total = 16'(len + 4);
            push_sym(C_SYM_MARK);
            code_frame_byte(total[7:0], 0);
            crc_update(total[7:0]);
            code_frame_byte(total[15:8], 1);
            crc_update(total[15:8]);
        end
        code_frame_byte(b, frm_idx + 2);
        crc_update(b);
        if (frm_idx + 1 >= len) begin
            crc = frm_crc;
            code_frame_byte(crc[7:0], len + 2);
            code_frame_byte(crc[15:8], len + 3);
            push_sym(C_SYM_END);
            frame_restart();
            frames_done++;
        end else begin
            frm_idx = (frm_idx + 1) & 32'h7FF;
        end
        foreach (step_syms[i]) begin
            e.sym  = step_syms[i];
            e.last = (i == step_syms.size() - 1);
            expected_syms.push_back(e);
        end
    endfunction

    // send one payload byte; valid stays high for a following item
    task automatic send_byte(logic [7:0] b);
        if (stall_on && $urandom_range(0, 3) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.data_byte <= b;
        @(posedge i_clk);
        while (!in_if.ready) begin
            @(posedge i_clk);
        end
        predict_symbols(b);
        items_sent++;
        prev_byte = b;
        @(negedge i_clk);
    endtask

    // stop input and wait until every expected symbol is out
    task automatic settle();
        in_if.valid <= 1'b0;
        @(negedge i_clk);
        while (expected_syms.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [10:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        @(negedge i_clk);
        if (idx == C_REG_PAYLOAD_LEN) begin
            cfg_len = value;
        end else begin
            cfg_sep = value;
        end
        cfg_writes++;
    endtask

    // random byte with a bias toward repeated nibbles
    function automatic logic [7:0] pick_byte();
        logic [7:0] r;
        r = 8'($urandom);
        case ($urandom_range(0, 7))
            0: return prev_byte;
            1: return {prev_byte[3:0], prev_byte[3:0]};
            2: return {r[3:0], r[3:0]};
            3: return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
            default: return r;
        endcase
    endfunction

    // first frames run on the reset settings
    task automatic test_reset_defaults();
        send_byte(8'h00);
        send_byte(8'hFF);
        settle();
    endtask

    // out-of-range lengths, seen in the length field; short frames via later writes
    task automatic test_length_clamp();
        write_reg(C_REG_SEP_OFFSET, 11'd2047);
        write_reg(C_REG_PAYLOAD_LEN, 11'd0);
        send_byte(8'hA5);
        settle();
        write_reg(C_REG_PAYLOAD_LEN, 11'd2047);
        send_byte(8'h3C);
        settle();
        write_reg(C_REG_PAYLOAD_LEN, 11'd1);
        send_byte(8'h3C);
        settle();
        write_reg(C_REG_PAYLOAD_LEN, 11'd1024);
        write_reg(C_REG_SEP_OFFSET, 11'd1024);
        send_byte(8'h00);
        settle();
        write_reg(C_REG_PAYLOAD_LEN, 11'd1);
        send_byte(8'h01);
        settle();
    endtask

    // separator in the payload and in front of each crc byte
    task automatic test_separator_slots();
        logic [10:0] slots[3];
        slots = '{11'd1, 11'd3, 11'd4};
        write_reg(C_REG_PAYLOAD_LEN, 11'd3);
        foreach (slots[i]) begin
            write_reg(C_REG_SEP_OFFSET, slots[i]);
            repeat (3) send_byte(pick_byte());
            settle();
        end
    endtask

    // runs of equal nibbles across byte borders
    task automatic test_repeat_runs();
        write_reg(C_REG_PAYLOAD_LEN, 11'd4);
        write_reg(C_REG_SEP_OFFSET, 11'd2047);
        send_byte(8'h00);
        send_byte(8'h11);
        send_byte(8'h11);
        send_byte(8'h1F);
        settle();
    endtask

    // length lowered below the bytes already taken: frame ends on the next byte
    task automatic test_midframe_shorten();
        write_reg(C_REG_PAYLOAD_LEN, 11'd5);
        write_reg(C_REG_SEP_OFFSET, 11'd1);
        repeat (3) send_byte(pick_byte());
        settle();
        write_reg(C_REG_PAYLOAD_LEN, 11'd2);
        send_byte(pick_byte());
        settle();
    endtask

    // random settings, mostly whole frames with random content
    task automatic test_random_frames(int unsigned n_items);
        int unsigned sent;
        int unsigned len;
        int unsigned cnt;
        logic [10:0] len_v;
        logic [10:0] sep_v;
        sent = 0;
        while (sent < n_items) begin
            stall_on = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 15))
                0: len_v = 11'd0;
                1: len_v = 11'($urandom_range(9, 40));
                2: len_v = 11'($urandom);
                default: len_v = 11'($urandom_range(1, 8));
            endcase
            if ($urandom_range(0, 4) != 0) begin
                write_reg(C_REG_PAYLOAD_LEN, len_v);
            end
            len = eff_length();
            if ($urandom_range(0, 5) == 0) begin
                sep_v = 11'($urandom);
            end else begin
                sep_v = 11'($urandom_range(0, len + 2));
            end
            if ($urandom_range(0, 4) != 0) begin
                write_reg(C_REG_SEP_OFFSET, sep_v);
            end
            if (len > 40) begin
                cnt = $urandom_range(1, 6);
            end else if ($urandom_range(0, 4) == 0) begin
                cnt = $urandom_range(1, len);
            end else begin
                cnt = len * $urandom_range(1, 3);
            end
            repeat (cnt) send_byte(pick_byte());
            sent += cnt;
            settle();
        end
    endtask

    // back-to-back traffic with no idling on either side
    task automatic test_unstalled_tail();
        stall_on = 1'b0;
        write_reg(C_REG_PAYLOAD_LEN, 11'd5);
        write_reg(C_REG_SEP_OFFSET, 11'd2);
        repeat (40) send_byte(pick_byte());
        settle();
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = C_REG_PAYLOAD_LEN;
        i_cfg_data      = 11'd0;
        in_if.valid     = 1'b0;
        in_if.data_byte = 8'h00;
        stall_on        = 1'b1;
        prev_byte       = 8'h00;
        fail_cnt        = 0;
        items_sent      = 0;
        syms_checked    = 0;
        frames_done     = 0;
        cfg_writes      = 0;
        cfg_len         = 11'd1;
        cfg_sep         = 11'd0;
        frame_restart();

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_defaults();
        test_length_clamp();
        test_separator_slots();
        test_repeat_runs();
        test_midframe_shorten();
        test_random_frames(290);
        test_unstalled_tail();

        repeat (20) @(negedge i_clk);
        $display("run covered %0d payload items, %0d frames, %0d symbols checked",
                 items_sent, frames_done, syms_checked);
        $display("%0d register writes across lengths, separator slots and repeat runs",
                 cfg_writes);
        if (fail_cnt == 0 && expected_syms.size() == 0) begin
            $display("[nibble_tone_symbol_framer_unit] OK");
        end else begin
            $display("[nibble_tone_symbol_framer_unit] ERROR");
        end
        $finish;
    end

endmodule

/* nibble_tone_symbol_framer_unit.f */
hdl/nts_pkg.sv
hdl/nts_byte_if.sv
hdl/nts_sym_if.sv
hdl/nibble_tone_symbol_framer_unit.sv
hdl/nts_checker.sv
verif/tb_nibble_tone_symbol_framer_unit.sv
